// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the matrix multiply RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must be followed by another one at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// A condition that must be preceded by another one at the previous clock edge.
`define ASSERT_AFTER(lbl, clk, rst_n, cons, ante, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cons) |-> $past(ante)) \
        else $error(msg);

`endif

// ----- hw/rtl/imm_pkg.sv -----
// Types and constants shared by the matrix multiply engine.
`default_nettype none

package imm_pkg;

    localparam int IN_MAX      = 64;
    localparam int OUT_MAX     = 64;
    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int ACT_AW      = $clog2(IN_MAX);
    localparam int OUT_AW      = 6;
    localparam int SIZE_W      = 7;
    localparam int DATA_W      = 8;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ACC_W       = 32;
    localparam int CFG_AW      = 2;

    localparam logic [CFG_AW-1:0] CFG_IN_FEATURES   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_OUT_FEATURES  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_WEIGHT_LAYOUT = 2'd2;

    localparam logic REQ_WEIGHT     = 1'b0;
    localparam logic REQ_ACTIVATION = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic [STORE_AW-1:0]      weight_index;
        logic signed [DATA_W-1:0] value;
    } imm_req_t;

    typedef struct packed {
        logic [OUT_AW-1:0]       output_index;
        logic signed [ACC_W-1:0] dot_value;
        logic                    last;
    } imm_result_t;

    // Marks that travel alongside one multiply-accumulate step.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last_k;
        logic              last_o;
        logic [OUT_AW-1:0] o;
    } imm_tag_t;

    typedef struct packed {
        logic                wr_weight;
        logic                wr_act;
        logic [ACT_AW-1:0]   act_wr_addr;
        logic [ACT_AW-1:0]   act_rd_addr;
        logic [STORE_AW-1:0] w_rd_addr;
        imm_tag_t            tag;
    } imm_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/imm_ctrl.sv -----
// Controller: configuration registers, activation counter and MAC sequencer.
`default_nettype none
`include "assert_macros.svh"

module imm_ctrl
    import imm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              req_type,
    output logic                   busy,
    input  wire logic              cfg_we,
    input  wire logic [CFG_AW-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0] cfg_data,
    output imm_cmd_t               cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                state_reg, state_next;
    logic [SIZE_W-1:0]   in_size_reg;
    logic [SIZE_W-1:0]   out_size_reg;
    logic                weight_layout_reg;
    logic [SIZE_W-1:0]   count_reg, count_next;
    logic [ACT_AW-1:0]   k_reg, k_next;
    logic [OUT_AW-1:0]   o_reg, o_next;
    logic [STORE_AW-1:0] addr_reg, addr_next;
    logic [SIZE_W-1:0]   k_n, m_n;
    logic [SIZE_W-1:0]   count_inc;
    logic                accept, act_accept, row_done;
    logic                last_k, last_o;

    // Sizes of zero act as one, sizes above the maximum saturate.
    always_comb
    begin
        if (in_size_reg == '0)
            k_n = SIZE_W'(1);
        else if (in_size_reg > SIZE_W'(IN_MAX))
            k_n = SIZE_W'(IN_MAX);
        else
            k_n = in_size_reg;
        if (out_size_reg == '0)
            m_n = SIZE_W'(1);
        else if (out_size_reg > SIZE_W'(OUT_MAX))
            m_n = SIZE_W'(OUT_MAX);
        else
            m_n = out_size_reg;
    end

    assign busy       = (state_reg == ST_RUN);
    assign accept     = start && !busy;
    assign act_accept = accept && (req_type == REQ_ACTIVATION);
    assign count_inc  = count_reg + SIZE_W'(1);
    assign row_done   = act_accept && (count_inc >= k_n);
    assign last_k     = (SIZE_W'(k_reg) == k_n - SIZE_W'(1));
    assign last_o     = (SIZE_W'(o_reg) == m_n - SIZE_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_size_reg       <= SIZE_W'(1);
            out_size_reg      <= SIZE_W'(1);
            weight_layout_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IN_FEATURES:   in_size_reg       <= cfg_data;
                CFG_OUT_FEATURES:  out_size_reg      <= cfg_data;
                CFG_WEIGHT_LAYOUT: weight_layout_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (act_accept)
            count_next = row_done ? '0 : count_inc;
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        o_next     = o_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (row_done)
                begin
                    state_next = ST_RUN;
                    k_next     = '0;
                    o_next     = '0;
                    addr_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (last_k)
                begin
                    k_next = '0;
                    if (last_o)
                        state_next = ST_IDLE;
                    else
                    begin
                        o_next = o_reg + OUT_AW'(1);
                        // Alternate layout restarts at the next output's column.
                        if (weight_layout_reg)
                            addr_next = STORE_AW'(o_reg) + STORE_AW'(1);
                        else
                            addr_next = addr_reg + STORE_AW'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + ACT_AW'(1);
                    if (weight_layout_reg)
                        addr_next = addr_reg + STORE_AW'(m_n);
                    else
                        addr_next = addr_reg + STORE_AW'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
            o_reg     <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            o_reg     <= o_next;
            addr_reg  <= addr_next;
        end
    end

    always_comb
    begin
        cmd.wr_weight  = accept && (req_type == REQ_WEIGHT);
        cmd.wr_act     = act_accept && (count_reg < SIZE_W'(IN_MAX));
        cmd.act_wr_addr = count_reg[ACT_AW-1:0];
        cmd.act_rd_addr = k_reg;
        cmd.w_rd_addr   = addr_reg;
        cmd.tag.valid   = busy;
        cmd.tag.first   = (k_reg == '0);
        cmd.tag.last_k  = last_k;
        cmd.tag.last_o  = last_o;
        cmd.tag.o       = o_reg;
    end

    `ASSERT_ALWAYS(a_run_in_range, clk, rst_n,
        !busy || ((SIZE_W'(k_reg) < k_n) && (SIZE_W'(o_reg) < m_n)),
        "sequencer indexes beyond the configured sizes")
    `ASSERT_NEXT(a_row_starts_run, clk, rst_n, row_done,
        busy && (k_reg == '0) && (o_reg == '0),
        "completed row did not start the sequencer")
    `ASSERT_ALWAYS(a_count_below_size, clk, rst_n,
        busy || (count_reg < SIZE_W'(IN_MAX)),
        "activation counter left its range")

endmodule

`default_nettype wire

// ----- hw/rtl/imm_datapath.sv -----
// Datapath: weight and activation memories, shared multiplier and accumulator.
`default_nettype none
`include "assert_macros.svh"

module imm_datapath
    import imm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire imm_req_t req,
    input  wire imm_cmd_t cmd,
    output logic          result_valid,
    output imm_result_t   result
);

    logic signed [DATA_W-1:0] weight_mem [STORE_DEPTH];
    logic signed [DATA_W-1:0] act_mem [IN_MAX];

    logic signed [DATA_W-1:0] w_rd_reg;
    logic signed [DATA_W-1:0] a_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    imm_tag_t                 s1_reg, s2_reg;
    logic                     result_valid_reg;
    imm_result_t              result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_weight)
            weight_mem[req.weight_index] <= req.value;
        w_rd_reg <= weight_mem[cmd.w_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_act)
            act_mem[cmd.act_wr_addr] <= req.value;
        a_rd_reg <= act_mem[cmd.act_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= w_rd_reg * a_rd_reg;
    end

    // The first product of an output replaces the running sum.
    always_comb
    begin
        if (s2_reg.first)
            acc_next = ACC_W'(prod_reg);
        else
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s2_reg.valid)
            acc_reg <= acc_next;
        if (s2_reg.valid && s2_reg.last_k)
        begin
            result_reg.output_index <= s2_reg.o;
            result_reg.dot_value    <= acc_next;
            result_reg.last         <= s2_reg.last_o;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg           <= '0;
            s2_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg           <= cmd.tag;
            s2_reg           <= s1_reg;
            result_valid_reg <= s2_reg.valid && s2_reg.last_k;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_NEXT(a_last_step_emits, clk, rst_n, s2_reg.valid && s2_reg.last_k,
        result_valid_reg, "final step of an output produced no word")
    `ASSERT_AFTER(a_word_has_step, clk, rst_n, result_valid_reg,
        s2_reg.valid && s2_reg.last_k, "result word without a final step")

endmodule

`default_nettype wire

// ----- hw/rtl/int8_matmul_engine.sv -----
// Top level of the signed 8-bit matrix multiply engine with 32-bit sums.
//
// Usage: configure the row length, the output count and the weight layout
// through the write port (cfg_we, cfg_index, cfg_data) while the block is
// idle. Every command word is presented on req with start and is taken at a
// clock edge where start is high and busy is low. A weight word is stored at
// its weight index, and an activation word at the next place in the row; the
// word that completes a row of activations starts the sequencer, and busy
// stays high until every output of the row is done, one multiply-accumulate
// per cycle in the single shared MAC fed by the weight memory's read port.
// Results come out in output order, one word per output, each registered
// after the memory reads, the product and the accumulator. Each word is valid
// for exactly one cycle with result_valid, and the final word of the row
// carries last. The receiver cannot stall the block.
// Reset clears the activation counter and sets the sizes to one and the
// layout to output-major. The memories are not cleared: a weight or
// activation must be written before it is used.
`default_nettype none

module int8_matmul_engine
    import imm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire imm_req_t          req,
    output logic                   result_valid,
    output imm_result_t            result,
    input  wire logic              cfg_we,
    input  wire logic [CFG_AW-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0] cfg_data
);

    imm_cmd_t cmd;

    imm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req.req_type),
        .busy      (busy),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd)
    );

    imm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
